/* src/alphabet_sequence_run_detector_defines.svh */
// assertion macros shared by the sequence run detector checker
`ifndef ALPHABET_SEQUENCE_RUN_DETECTOR_DEFINES_SVH
`define ALPHABET_SEQUENCE_RUN_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ASRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/asrd_pkg.sv */
// shared types and constants of the alphabet sequence run detector
package asrd_pkg;

  // field widths
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 5;
  localparam int LEN_W    = 6;
  localparam int START_W  = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ALPHA_LEN_W = 6;

  // alphabet storage layout
  localparam int ALPHA_CHARS     = 32;
  localparam int CHARS_PER_WORD  = 8;
  localparam int ALPHA_WORD_BASE = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WORD3 = 3'd4;

  // input opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // run limits
  localparam logic [LEN_W-1:0] MIN_RUN = 6'd3;
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

  // result of one alphabet lookup
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } lookup_t;

endpackage

/* src/asrd_lookup.sv */
// lowercase folding and first-occurrence search in the configured alphabet
module asrd_lookup
  import asrd_pkg::*;
#(
  parameter int LOOKUP_N = 32
) (
  input  logic [CHAR_W-1:0]                 char_code,
  input  logic [LOOKUP_N-1:0][CHAR_W-1:0]   chars,
  input  logic [ALPHA_LEN_W-1:0]            alpha_len,
  output lookup_t                           res
);

  localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
  localparam logic [ALPHA_LEN_W-1:0] N_MAX = ALPHA_LEN_W'(LOOKUP_N);

  logic [CHAR_W-1:0]      ch_lc;
  logic [ALPHA_LEN_W-1:0] eff_len;
  logic [LOOKUP_N-1:0]    match;

  // ascii lowercase, other codes pass unchanged
  assign ch_lc = (char_code >= UPPER_A && char_code <= UPPER_Z) ?
                 (char_code | CASE_BIT) : char_code;

  // clamp the configured length to the stored alphabet
  assign eff_len = (alpha_len > N_MAX) ? N_MAX : alpha_len;

  // parallel compare against every live alphabet slot
  always_comb begin
    for (int k = 0; k < LOOKUP_N; k++) begin
      match[k] = (chars[k] == ch_lc) && (ALPHA_LEN_W'(k) < eff_len);
    end
  end

  // priority encode, lowest index wins
  always_comb begin
    res.hit = 1'b0;
    res.idx = '0;
    for (int k = LOOKUP_N - 1; k >= 0; k--) begin
      if (match[k]) begin
        res.hit = 1'b1;
        res.idx = IDX_W'(k);
      end
    end
  end

endmodule

/* src/alphabet_sequence_run_detector.sv */
// top level of the alphabet sequence run detector
//
// Input channel (in_valid/in_ready): one beat per character, in_opcode low,
// or an end-of-string beat, in_opcode high. Characters are folded to ascii
// lowercase and looked up in the alphabet set up on the cfg_ port.
// Result channel (out_valid/out_ready): one beat per run of three or more
// alphabet indices stepping by +1 or -1, sent when the run breaks (mismatch,
// character outside the alphabet or end of string). End of string also
// clears the run state and the string position.
// A result leaves through the input register, then the result register,
// after the beat that breaks the run is accepted.
// Throughput: one beat per cycle unless stalled; the lookup and the state
// update sit in a single stage between the input register and the result
// register. A stalled receiver holds the result register; the input register
// still takes one more beat, then in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, clears the run
// state and sets the alphabet length to zero. cfg_ writes take effect at once;
// the user makes them only while the block is idle; the block does not check it.
module alphabet_sequence_run_detector
  import asrd_pkg::*;
#(
  parameter int ALPHABET_MAX   = 32,
  parameter int MAX_STRING_LEN = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [CHAR_W-1:0]     in_char_code,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [START_W-1:0]    out_match_start,
  output logic [LEN_W-1:0]      out_match_length,
  output logic [IDX_W-1:0]      out_alphabet_start,
  output logic                  out_ascending
);

  localparam int LOOKUP_N = (ALPHABET_MAX < ALPHA_CHARS) ? ALPHABET_MAX : ALPHA_CHARS;
  localparam int POS_W    = $clog2(MAX_STRING_LEN);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LEN - 1);

  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_START,
    MODE_SEQ
  } mode_t;

  // alphabet configuration
  logic [ALPHA_LEN_W-1:0]             alpha_len_r;
  logic [LOOKUP_N-1:0][CHAR_W-1:0]    chars_r;

  // input register
  logic                s1_valid_r;
  logic                s1_op_r;
  logic [CHAR_W-1:0]   s1_char_r;

  // run state
  mode_t               mode_r, mode_nxt;
  logic                prev_valid_r, prev_valid_nxt;
  logic [IDX_W-1:0]    prev_idx_r, prev_idx_nxt;
  logic [IDX_W-1:0]    run_start_idx_r, run_start_idx_nxt;
  logic [LEN_W-1:0]    run_len_r, run_len_nxt;
  logic                run_dir_r, run_dir_nxt;
  logic [POS_W-1:0]    run_start_pos_r, run_start_pos_nxt;
  logic [POS_W-1:0]    str_pos_r, str_pos_nxt;

  // result register
  logic                out_valid_r;
  logic [START_W-1:0]  out_match_start_r;
  logic [LEN_W-1:0]    out_match_length_r;
  logic [IDX_W-1:0]    out_alphabet_start_r;
  logic                out_ascending_r;

  lookup_t             lk;
  logic                advance;
  logic                emit;
  logic                emit_ok;
  logic                step_up;
  logic                step_dn;
  logic                step_want;

  asrd_lookup #(
    .LOOKUP_N (LOOKUP_N)
  ) u_lookup (
    .char_code (s1_char_r),
    .chars     (chars_r),
    .alpha_len (alpha_len_r),
    .res       (lk)
  );

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = rst_n && (!s1_valid_r || advance);

  // step direction against the previous index
  assign step_up = (mode_r != MODE_SEARCH) && prev_valid_r && lk.hit &&
                   ({1'b0, lk.idx} == ({1'b0, prev_idx_r} + 6'd1));
  assign step_dn = (mode_r != MODE_SEARCH) && prev_valid_r && lk.hit &&
                   (({1'b0, lk.idx} + 6'd1) == {1'b0, prev_idx_r});
  assign step_want = run_dir_r ? step_up : step_dn;
  assign emit_ok   = (mode_r == MODE_SEQ) && (run_len_r >= MIN_RUN);

  // next run state for the beat in the input register
  always_comb begin
    mode_nxt          = mode_r;
    prev_valid_nxt    = prev_valid_r;
    prev_idx_nxt      = prev_idx_r;
    run_start_idx_nxt = run_start_idx_r;
    run_len_nxt       = run_len_r;
    run_dir_nxt       = run_dir_r;
    run_start_pos_nxt = run_start_pos_r;
    str_pos_nxt       = str_pos_r;
    emit              = 1'b0;

    if (s1_op_r == OP_EOS) begin
      emit              = emit_ok;
      mode_nxt          = MODE_SEARCH;
      prev_valid_nxt    = 1'b0;
      prev_idx_nxt      = '0;
      run_start_idx_nxt = '0;
      run_len_nxt       = '0;
      run_dir_nxt       = 1'b0;
      run_start_pos_nxt = '0;
      str_pos_nxt       = '0;
    end else begin
      unique case (mode_r)
        MODE_START: begin
          if (step_up || step_dn) begin
            mode_nxt    = MODE_SEQ;
            run_dir_nxt = step_up;
            run_len_nxt = 6'd2;
          end else begin
            mode_nxt = MODE_SEARCH;
          end
        end
        MODE_SEQ: begin
          if (step_want) begin
            if (run_len_r < LEN_MAX) begin
              run_len_nxt = run_len_r + 6'd1;
            end
          end else begin
            emit     = emit_ok;
            mode_nxt = MODE_SEARCH;
          end
        end
        default: begin
          mode_nxt = MODE_SEARCH;
        end
      endcase

      if (!lk.hit) begin
        mode_nxt = MODE_SEARCH;
      end

      // a character in the alphabet opens a new run when none continues
      if (mode_nxt == MODE_SEARCH && lk.hit) begin
        mode_nxt          = MODE_START;
        run_start_idx_nxt = lk.idx;
        run_dir_nxt       = 1'b0;
        run_len_nxt       = 6'd1;
        run_start_pos_nxt = str_pos_r;
      end

      prev_valid_nxt = lk.hit;
      prev_idx_nxt   = lk.hit ? lk.idx : '0;
      if (str_pos_r < POS_MAX) begin
        str_pos_nxt = str_pos_r + POS_W'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_len_r <= '0;
      chars_r     <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_ALPHA_LEN) begin
        alpha_len_r <= cfg_wdata[ALPHA_LEN_W-1:0];
      end
      for (int k = 0; k < LOOKUP_N; k++) begin
        if (cfg_index == CFG_IDX_W'(ALPHA_WORD_BASE + k / CHARS_PER_WORD)) begin
          chars_r[k] <= cfg_wdata[(k % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_op_r   <= in_opcode;
      s1_char_r <= in_char_code;
    end
  end

  // run state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_SEARCH;
      prev_valid_r    <= 1'b0;
      prev_idx_r      <= '0;
      run_start_idx_r <= '0;
      run_len_r       <= '0;
      run_dir_r       <= 1'b0;
      run_start_pos_r <= '0;
      str_pos_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (advance) begin
        mode_r          <= mode_nxt;
        prev_valid_r    <= prev_valid_nxt;
        prev_idx_r      <= prev_idx_nxt;
        run_start_idx_r <= run_start_idx_nxt;
        run_len_r       <= run_len_nxt;
        run_dir_r       <= run_dir_nxt;
        run_start_pos_r <= run_start_pos_nxt;
        str_pos_r       <= str_pos_nxt;
        out_valid_r     <= emit;
      end else if (out_ready) begin
        out_valid_r     <= 1'b0;
      end
    end
    if (advance && emit) begin
      out_match_start_r    <= START_W'(run_start_pos_r);
      out_match_length_r   <= run_len_r;
      out_alphabet_start_r <= run_start_idx_r;
      out_ascending_r      <= run_dir_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_match_start    = out_match_start_r;
  assign out_match_length   = out_match_length_r;
  assign out_alphabet_start = out_alphabet_start_r;
  assign out_ascending      = out_ascending_r;

endmodule

/* src/asrd_checker.sv */
// port-level assertions for the alphabet sequence run detector
`include "alphabet_sequence_run_detector_defines.svh"

module asrd_checker
  import asrd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [START_W-1:0] out_match_start,
  input logic [LEN_W-1:0]   out_match_length,
  input logic [IDX_W-1:0]   out_alphabet_start,
  input logic               out_ascending
);

  // a stalled result beat holds
  `ASRD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_match_start) && $stable(out_match_length) && $stable(out_alphabet_start) && $stable(out_ascending), "result beat changed while stalled")

  // reported runs are at least the minimum length
  `ASRD_ASSERT_SAME(a_min_len, clk, rst_n, out_valid, out_match_length >= MIN_RUN, "run shorter than minimum reported")

  // an ascending run stays inside the alphabet
  `ASRD_ASSERT_SAME(a_up_range, clk, rst_n, out_valid && out_ascending, (7'(out_alphabet_start) + 7'(out_match_length)) <= 7'd32, "ascending run leaves the alphabet")

  // a descending run does not go below index zero
  `ASRD_ASSERT_SAME(a_dn_range, clk, rst_n, out_valid && !out_ascending, (7'(out_alphabet_start) + 7'd1) >= 7'(out_match_length), "descending run goes below index zero")

  // a fresh result follows an accepted beat through the input and result registers
  `ASRD_ASSERT_SAME(a_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a matching input beat")

endmodule

bind alphabet_sequence_run_detector asrd_checker u_asrd_checker (.*);

/* verif/tb_top.sv */
// self-checking testbench of the alphabet sequence run detector: directed table, then random runs
module tb_top;
  import asrd_pkg::*;

  localparam int STRING_LEN    = 1024;
  localparam int POS_LAST      = STRING_LEN - 1;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;

  // alphabet "abcdefghijklmnopqrstuvwxyz012345", lowest byte first
  localparam logic [CFG_DATA_W-1:0] FULL_W0 = "hgfedcba";
  localparam logic [CFG_DATA_W-1:0] FULL_W1 = "ponmlkji";
  localparam logic [CFG_DATA_W-1:0] FULL_W2 = "xwvutsrq";
  localparam logic [CFG_DATA_W-1:0] FULL_W3 = "543210zy";
  localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

  typedef enum logic [1:0] {SCAN_SEARCH, SCAN_START, SCAN_SEQ} scan_mode_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [IDX_W-1:0]   astart;
    logic               asc;
  } run_t;

  // one directed beat; known rows carry a typed-in expectation
  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic              known;
    logic              hit;
    run_t              run;
  } step_row_t;

  localparam run_t NO_RUN = '0;

  localparam step_row_t STEPS [0:20] = '{
    '{OP_CHAR, "a",   1'b1, 1'b0, NO_RUN},
    '{OP_CHAR, "B",   1'b0, 1'b0, NO_RUN},
    '{OP_CHAR, "c",   1'b0, 1'b0, NO_RUN},
    '{OP_CHAR, "d",   1'b0, 1'b0, NO_RUN},
    // step off the run: ascending a..d reported, new run at x
    '{OP_CHAR, "x",   1'b1, 1'b1, '{10'd0, 6'd4, 5'd0, 1'b1}},
    '{OP_CHAR, "w",   1'b0, 1'b0, NO_RUN},
    '{OP_CHAR, "v",   1'b0, 1'b0, NO_RUN},
    // character outside the alphabet ends descending x..v
    '{OP_CHAR, "!",   1'b1, 1'b1, '{10'd4, 6'd3, 5'd23, 1'b0}},
    '{OP_CHAR, "f",   1'b0, 1'b0, NO_RUN},
    '{OP_CHAR, "g",   1'b0, 1'b0, NO_RUN},
    // run of two dropped, new run starts at z
    '{OP_CHAR, "Z",   1'b1, 1'b0, NO_RUN},
    '{OP_CHAR, "0",   1'b0, 1'b0, NO_RUN},
    '{OP_CHAR, "1",   1'b0, 1'b0, NO_RUN},
    '{OP_EOS,  8'h00, 1'b1, 1'b1, '{10'd10, 6'd3, 5'd25, 1'b1}},
    // top of the alphabet, descending, flushed by end of string
    '{OP_CHAR, "5",   1'b0, 1'b0, NO_RUN},
    '{OP_CHAR, "4",   1'b0, 1'b0, NO_RUN},
    '{OP_CHAR, "3",   1'b0, 1'b0, NO_RUN},
    '{OP_EOS,  8'hFF, 1'b1, 1'b1, '{10'd0, 6'd3, 5'd31, 1'b0}},
    '{OP_CHAR, 8'h00, 1'b1, 1'b0, NO_RUN},
    '{OP_CHAR, 8'hFF, 1'b1, 1'b0, NO_RUN},
    '{OP_EOS,  8'h00, 1'b1, 1'b0, NO_RUN}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_opcode;
  logic [CHAR_W-1:0]     in_char_code;
  logic                  out_valid;
  logic                  out_ready;
  logic [START_W-1:0]    out_match_start;
  logic [LEN_W-1:0]      out_match_length;
  logic [IDX_W-1:0]      out_alphabet_start;
  logic                  out_ascending;

  // alphabet shadow and scan state of the predictor
  logic [ALPHA_LEN_W-1:0] alpha_len;
  logic [CFG_DATA_W-1:0]  alpha_words [4];
  scan_mode_t             sc_mode;
  logic                   sc_prev_hit;
  logic [IDX_W-1:0]       sc_prev;
  logic [IDX_W-1:0]       sc_idx0;
  logic [LEN_W-1:0]       sc_len;
  logic                   sc_up;
  logic [START_W-1:0]     sc_pos0;
  logic [START_W-1:0]     sc_pos;

  run_t runs_due [$];
  run_t head_run;
  int   mismatches = 0;
  int   beats_sent = 0;
  int   quiet_cycles = 0;
  bit   idle_on = 1'b1;
  bit   hold_off = 1'b0;

  alphabet_sequence_run_detector #(
    .ALPHABET_MAX  (32),
    .MAX_STRING_LEN(STRING_LEN)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_match_start   (out_match_start),
    .out_match_length  (out_match_length),
    .out_alphabet_start(out_alphabet_start),
    .out_ascending     (out_ascending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] ERROR %s: got %0d, want %0d", $time, field, got, want);
    mismatches++;
  endtask

  function automatic int live_len();
    return (alpha_len > ALPHA_CHARS) ? ALPHA_CHARS : int'(alpha_len);
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input int k);
    return alpha_words[k / CHARS_PER_WORD][(k % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
  endfunction

  // lowest alphabet index holding the character
  function automatic lookup_t find_in_alphabet(input logic [CHAR_W-1:0] ch);
    lookup_t found;
    found = '0;
    for (int k = live_len() - 1; k >= 0; k--) begin
      if (alpha_char(k) == ch) begin
        found.hit = 1'b1;
        found.idx = IDX_W'(k);
      end
    end
    return found;
  endfunction

  task automatic clear_scan();
    sc_mode     = SCAN_SEARCH;
    sc_prev_hit = 1'b0;
    sc_prev     = '0;
    sc_idx0     = '0;
    sc_len      = '0;
    sc_up       = 1'b0;
    sc_pos0     = '0;
    sc_pos      = '0;
  endtask

  // run detection for one beat; found is set when a run is reported
  task automatic advance_scan(input logic op, input logic [CHAR_W-1:0] ch,
                              output bit found, output run_t res);
    lookup_t           lk;
    logic [CHAR_W-1:0] low;
    bit                fwd;
    bit                rev;
    found = 1'b0;
    res   = NO_RUN;
    if (op == OP_EOS) begin
      if (sc_mode == SCAN_SEQ && sc_len >= MIN_RUN) begin
        found = 1'b1;
        res   = '{sc_pos0, sc_len, sc_idx0, sc_up};
      end
      clear_scan();
      return;
    end
    low = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
    lk  = find_in_alphabet(low);
    fwd = sc_mode != SCAN_SEARCH && sc_prev_hit && lk.hit && int'(lk.idx) == int'(sc_prev) + 1;
    rev = sc_mode != SCAN_SEARCH && sc_prev_hit && lk.hit && int'(lk.idx) + 1 == int'(sc_prev);
    case (sc_mode)
      SCAN_START: begin
        if (fwd || rev) begin
          sc_mode = SCAN_SEQ;
          sc_up   = fwd;
          sc_len  = LEN_W'(2);
        end else begin
          sc_mode = SCAN_SEARCH;
        end
      end
      SCAN_SEQ: begin
        if (sc_up ? fwd : rev) begin
          if (sc_len < LEN_MAX) sc_len = sc_len + 1'b1;
        end else begin
          if (sc_len >= MIN_RUN) begin
            found = 1'b1;
            res   = '{sc_pos0, sc_len, sc_idx0, sc_up};
          end
          sc_mode = SCAN_SEARCH;
        end
      end
      default: sc_mode = SCAN_SEARCH;
    endcase
    if (!lk.hit) sc_mode = SCAN_SEARCH;
    // a fresh run starts at this character
    if (sc_mode == SCAN_SEARCH && lk.hit) begin
      sc_mode = SCAN_START;
      sc_idx0 = lk.idx;
      sc_up   = 1'b0;
      sc_len  = LEN_W'(1);
      sc_pos0 = sc_pos;
    end
    sc_prev_hit = lk.hit;
    sc_prev     = lk.hit ? lk.idx : '0;
    if (sc_pos < POS_LAST) sc_pos = sc_pos + 1'b1;
  endtask

  // offer one beat, hold it until taken, then log what it should produce
  task automatic send_beat(input logic op, input logic [CHAR_W-1:0] ch, input logic known,
                           input logic known_hit, input run_t known_run);
    int   gap;
    bit   found;
    run_t res;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_scan(op, ch, found, res);
    if (known) begin
      found = known_hit;
      res   = known_run;
    end
    if (found) runs_due.push_back(res);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_runs();
    while (runs_due.size() != 0) @(negedge clk);
  endtask

  // write every register while the block is idle
  task automatic load_alphabet(input logic [ALPHA_LEN_W-1:0] len,
                               input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                               input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3);
    logic [CFG_DATA_W-1:0] words [4];
    logic [CFG_IDX_W-1:0]  reg_idx;
    words = '{w0, w1, w2, w3};
    in_valid <= 1'b0;
    drain_runs();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ALPHA_LEN;
    cfg_wdata <= CFG_DATA_W'(len);
    @(negedge clk);
    for (reg_idx = CFG_ALPHA_WORD0; reg_idx <= CFG_ALPHA_WORD3; reg_idx++) begin
      cfg_index <= reg_idx;
      cfg_wdata <= words[reg_idx - CFG_ALPHA_WORD0];
      @(negedge clk);
    end
    cfg_wr_en   <= 1'b0;
    alpha_len   = len;
    alpha_words = words;
  endtask

  // a run through the alphabet with random start, direction and length, then maybe noise
  task automatic send_burst(input bit allow_eos);
    int                n;
    int                pos;
    int                span;
    int                pick;
    bit                up;
    logic [CHAR_W-1:0] ch;
    n = live_len();
    if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
    if (n != 0) begin
      pos  = $urandom_range(0, n - 1);
      up   = $urandom_range(0, 1);
      span = ($urandom_range(0, 9) == 0) ? n : $urandom_range(1, 6);
      repeat (span) begin
        if (pos < 0 || pos >= n) break;
        ch = alpha_char(pos);
        if (ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0) ch = ch - 8'd32;
        send_beat(OP_CHAR, ch, 1'b0, 1'b0, NO_RUN);
        pos = up ? pos + 1 : pos - 1;
      end
    end
    pick = $urandom_range(0, 9);
    if (allow_eos && pick < 2)
      send_beat(OP_EOS, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, NO_RUN);
    else if (pick < 4 || n == 0)
      send_beat(OP_CHAR, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, NO_RUN);
  endtask

  task automatic run_phase(input int beats, input bit allow_eos);
    int target;
    target = beats_sent + beats;
    while (beats_sent < target) send_burst(allow_eos);
  endtask

  // stimulus
  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_ALPHA_LEN;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_opcode    = OP_CHAR;
    in_char_code = '0;
    alpha_len    = '0;
    alpha_words  = '{'0, '0, '0, '0};
    clear_scan();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    load_alphabet(6'd32, FULL_W0, FULL_W1, FULL_W2, FULL_W3);
    foreach (STEPS[r])
      send_beat(STEPS[r].op, STEPS[r].ch, STEPS[r].known, STEPS[r].hit, STEPS[r].run);

    // receiver held back halfway, sender keeps going
    load_alphabet(6'd32, FULL_W0, FULL_W1, FULL_W2, FULL_W3);
    run_phase(35, 1'b1);
    hold_off = 1'b1;
    run_phase(35, 1'b1);

    // oversize length, random bytes; sender pauses until all runs are out
    load_alphabet(6'd63, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    run_phase(35, 1'b1);
    drain_runs();
    run_phase(35, 1'b1);

    // empty, single and two-entry alphabets never report, then a three-entry one
    load_alphabet(6'd0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    run_phase(30, 1'b1);
    load_alphabet(6'd1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    run_phase(30, 1'b1);
    load_alphabet(6'd2, FULL_W0, '0, '0, '0);
    run_phase(30, 1'b1);
    load_alphabet(6'd3, CFG_DATA_W'("zyx"), '0, '0, '0);
    run_phase(40, 1'b1);

    // repeated characters resolve to the lowest index, then an oversize length
    load_alphabet(6'd16, "ddccbbaa", "hhggffee", '0, '0);
    run_phase(60, 1'b1);
    load_alphabet(6'd33, FULL_W0, FULL_W1, FULL_W2, {$urandom, $urandom});
    run_phase(60, 1'b1);

    // a longer string with no end-of-string beats, then flush
    load_alphabet(6'd32, FULL_W0, FULL_W1, FULL_W2, FULL_W3);
    run_phase(40, 1'b0);
    send_beat(OP_EOS, 8'h00, 1'b0, 1'b0, NO_RUN);

    load_alphabet(ALPHA_LEN_W'($urandom_range(4, 31)), {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    run_phase(60, 1'b1);

    in_valid <= 1'b0;
    drain_runs();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("alphabet_sequence_run_detector: match");
    else
      $display("alphabet_sequence_run_detector: mismatch");
    $finish;
  end

  // result side: random wait per beat, one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
          if (out_ready) out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!(out_valid && out_ready) && !hold_off) @(posedge clk);
        @(negedge clk);
      end
    end
  end

  // compare each result beat with the oldest pending run
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (runs_due.size() == 0) begin
        report_mismatch("result with nothing pending, match_start", out_match_start, 0);
      end else begin
        head_run = runs_due.pop_front();
        if (out_match_start !== head_run.start)
          report_mismatch("match_start", out_match_start, head_run.start);
        if (out_match_length !== head_run.len)
          report_mismatch("match_length", out_match_length, head_run.len);
        if (out_alphabet_start !== head_run.astart)
          report_mismatch("alphabet_start", out_alphabet_start, head_run.astart);
        if (out_ascending !== head_run.asc)
          report_mismatch("ascending", out_ascending, head_run.asc);
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("alphabet_sequence_run_detector: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* alphabet_sequence_run_detector.f */
+incdir+src
src/asrd_pkg.sv
src/asrd_lookup.sv
src/alphabet_sequence_run_detector.sv
src/asrd_checker.sv
verif/tb_top.sv
